// ----- rtl/core/i2cbb_pkg.sv -----
// ----------------------------------------------------------------------------
// i2cbb_pkg
// Shared types and constants of the i2c bit-level master sequencer.
// ----------------------------------------------------------------------------
package i2cbb_pkg;

   localparam int CNT_W     = 16;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DAT_W = 16;

   localparam logic [CNT_W-1:0] DELAY_TICKS_RST = CNT_W'(125);
   localparam logic [CNT_W-1:0] ACK_TIMEOUT_RST = CNT_W'(10000);

   localparam logic [CSR_IDX_W-1:0] CSR_DELAY_TICKS = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_ACK_TIMEOUT = 1'b1;

   typedef enum logic [2:0] {
      CMD_NONE  = 3'd0,
      CMD_START = 3'd1,
      CMD_STOP  = 3'd2,
      CMD_WRITE = 3'd3,
      CMD_READ  = 3'd4,
      CMD_WACK  = 3'd5
   } cmd_type;

   typedef enum logic [4:0] {
      PH_IDLE = 5'd0,
      PH_ST1  = 5'd1,
      PH_ST2  = 5'd2,
      PH_ST3  = 5'd3,
      PH_SP1  = 5'd4,
      PH_SP2  = 5'd5,
      PH_SP3  = 5'd6,
      PH_WR1  = 5'd7,
      PH_WR2  = 5'd8,
      PH_WR3  = 5'd9,
      PH_RD1  = 5'd10,
      PH_RD2  = 5'd11,
      PH_RA1  = 5'd12,
      PH_RA2  = 5'd13,
      PH_WACK = 5'd14
   } phase_type;

   typedef struct packed {
      logic [2:0] cmd;
      logic [7:0] tx_byte;
      logic       master_ack;
      logic       sda_in;
   } req_item_type;

   typedef struct packed {
      logic       scl;
      logic       sda_release;
      logic       busy_res;
      logic       done_res;
      logic [7:0] rx_data;
      logic       no_ack;
   } rsp_item_type;

endpackage

// ----- rtl/core/i2c_bitbang_master.sv -----
// ----------------------------------------------------------------------------
// i2c_bitbang_master
// I2C master pin sequencer: one beat per tick in, one result beat per tick out.
//
//   channel  dir  handshake              payload
//   req      in   req_valid/req_ready    cmd, tx_byte, master_ack, sda_in
//   rsp      out  rsp_valid/rsp_ready    scl, sda_release, busy_res, done_res,
//                                        rx_data, no_ack
//   csr      in   csr_we                 csr_index, csr_wdata
//
// one beat per cycle unless rsp stalls; result goes input reg, then result reg
// each tick is one pass through the step logic between input and result regs
// rsp stall holds the input register; req_ready drops only while both are full
// synchronous reset restores delay_ticks 125, ack_timeout 10000, lines released
// ----------------------------------------------------------------------------
module i2c_bitbang_master (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [2:0]                          req_cmd,
   input  logic [7:0]                          req_tx_byte,
   input  logic                                req_master_ack,
   input  logic                                req_sda_in,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_scl,
   output logic                                rsp_sda_release,
   output logic                                rsp_busy_res,
   output logic                                rsp_done_res,
   output logic [7:0]                          rsp_rx_data,
   output logic                                rsp_no_ack,
   input  logic                                csr_we,
   input  logic [i2cbb_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [i2cbb_pkg::CSR_DAT_W-1:0]     csr_wdata
);
   import i2cbb_pkg::*;

   logic         in_valid_ff, in_valid_in;
   req_item_type in_item_ff;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_item_ff;
   rsp_item_type step_result;
   logic         step_fire;
   logic         req_take;

   assign step_fire   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready   = !in_valid_ff || step_fire;
   assign req_take    = req_valid && req_ready;
   assign in_valid_in = req_take || (in_valid_ff && !step_fire);
   assign rsp_valid_in = step_fire || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff.cmd        <= req_cmd;
         in_item_ff.tx_byte    <= req_tx_byte;
         in_item_ff.master_ack <= req_master_ack;
         in_item_ff.sda_in     <= req_sda_in;
      end
      if (step_fire) begin
         rsp_item_ff <= step_result;
      end
   end

   i2cbb_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .step_fire (step_fire),
      .item      (in_item_ff),
      .result    (step_result)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_scl         = rsp_item_ff.scl;
   assign rsp_sda_release = rsp_item_ff.sda_release;
   assign rsp_busy_res    = rsp_item_ff.busy_res;
   assign rsp_done_res    = rsp_item_ff.done_res;
   assign rsp_rx_data     = rsp_item_ff.rx_data;
   assign rsp_no_ack      = rsp_item_ff.no_ack;

endmodule

// ----- rtl/core/i2cbb_seq.sv -----
// ----------------------------------------------------------------------------
// i2cbb_seq
// Pin sequencer state and per-tick step: takes one registered beat and
// produces the pin levels and flags after that tick.
// ----------------------------------------------------------------------------
module i2cbb_seq (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_we,
   input  logic [i2cbb_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [i2cbb_pkg::CSR_DAT_W-1:0]        csr_wdata,
   input  logic                                   step_fire,
   input  i2cbb_pkg::req_item_type                item,
   output i2cbb_pkg::rsp_item_type                result
);
   import i2cbb_pkg::*;

   logic [CNT_W-1:0] delay_ticks_ff, ack_timeout_ff;
   phase_type        phase_ff, phase_in;
   logic [3:0]       bit_count_ff, bit_count_in;
   logic [7:0]       shift_reg_ff, shift_reg_in;
   logic [CNT_W-1:0] delay_count_ff, delay_count_in;
   logic [CNT_W-1:0] timeout_count_ff, timeout_count_in;
   logic             scl_level_ff, scl_level_in;
   logic             sda_level_ff, sda_level_in;
   logic [7:0]       received_byte_ff, received_byte_in;
   logic             ack_flag_ff, ack_flag_in;
   logic             ack_to_send_ff, ack_to_send_in;

   logic [CNT_W-1:0] delay_load, timeout_load;
   logic [3:0]       bit_next;
   logic             done;

   // csr writes
   always_ff @(posedge clock) begin
      if (reset) begin
         delay_ticks_ff <= DELAY_TICKS_RST;
         ack_timeout_ff <= ACK_TIMEOUT_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_DELAY_TICKS: delay_ticks_ff <= CNT_W'(csr_wdata);
            CSR_ACK_TIMEOUT: ack_timeout_ff <= CNT_W'(csr_wdata);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_IDLE;
         bit_count_ff     <= '0;
         shift_reg_ff     <= '0;
         delay_count_ff   <= '0;
         timeout_count_ff <= '0;
         scl_level_ff     <= 1'b1;
         sda_level_ff     <= 1'b1;
         received_byte_ff <= '0;
         ack_flag_ff      <= 1'b0;
         ack_to_send_ff   <= 1'b0;
      end else if (step_fire) begin
         phase_ff         <= phase_in;
         bit_count_ff     <= bit_count_in;
         shift_reg_ff     <= shift_reg_in;
         delay_count_ff   <= delay_count_in;
         timeout_count_ff <= timeout_count_in;
         scl_level_ff     <= scl_level_in;
         sda_level_ff     <= sda_level_in;
         received_byte_ff <= received_byte_in;
         ack_flag_ff      <= ack_flag_in;
         ack_to_send_ff   <= ack_to_send_in;
      end
   end

   assign delay_load   = (delay_ticks_ff == '0) ? CNT_W'(1) : delay_ticks_ff;
   assign timeout_load = (ack_timeout_ff == '0) ? CNT_W'(1) : ack_timeout_ff;
   assign bit_next     = bit_count_ff + 4'd1;

   always_comb begin
      phase_in         = phase_ff;
      bit_count_in     = bit_count_ff;
      shift_reg_in     = shift_reg_ff;
      delay_count_in   = delay_count_ff;
      timeout_count_in = timeout_count_ff;
      scl_level_in     = scl_level_ff;
      sda_level_in     = sda_level_ff;
      received_byte_in = received_byte_ff;
      ack_flag_in      = ack_flag_ff;
      ack_to_send_in   = ack_to_send_ff;
      done             = 1'b0;

      unique case (phase_ff)
         PH_IDLE: begin
            unique case (item.cmd)
               CMD_START: begin
                  sda_level_in   = 1'b1;
                  delay_count_in = delay_load;
                  phase_in       = PH_ST1;
               end
               CMD_STOP: begin
                  scl_level_in   = 1'b0;
                  sda_level_in   = 1'b0;
                  delay_count_in = delay_load;
                  phase_in       = PH_SP1;
               end
               CMD_WRITE: begin
                  shift_reg_in   = item.tx_byte;
                  bit_count_in   = '0;
                  scl_level_in   = 1'b0;
                  delay_count_in = delay_load;
                  phase_in       = PH_WR1;
               end
               CMD_READ: begin
                  ack_to_send_in = item.master_ack;
                  shift_reg_in   = '0;
                  bit_count_in   = '0;
                  sda_level_in   = 1'b1;
                  delay_count_in = delay_load;
                  phase_in       = PH_RD1;
               end
               CMD_WACK: begin
                  sda_level_in     = 1'b1;
                  scl_level_in     = 1'b1;
                  timeout_count_in = timeout_load;
                  phase_in         = PH_WACK;
               end
               default: ;
            endcase
         end
         PH_WACK: begin
            if (!item.sda_in) begin
               scl_level_in = 1'b0;
               ack_flag_in  = 1'b0;
               done         = 1'b1;
               phase_in     = PH_IDLE;
            end else if (timeout_count_ff <= CNT_W'(1)) begin
               timeout_count_in = '0;
               ack_flag_in      = 1'b1;
               done             = 1'b1;
               phase_in         = PH_IDLE;
            end else begin
               timeout_count_in = timeout_count_ff - CNT_W'(1);
            end
         end
         default: begin
            if (delay_count_ff > CNT_W'(1)) begin
               delay_count_in = delay_count_ff - CNT_W'(1);
            end else begin
               delay_count_in = '0;
               unique case (phase_ff)
                  PH_ST1: begin
                     scl_level_in = 1'b1; delay_count_in = delay_load; phase_in = PH_ST2;
                  end
                  PH_ST2: begin
                     sda_level_in = 1'b0; delay_count_in = delay_load; phase_in = PH_ST3;
                  end
                  PH_ST3: begin
                     scl_level_in = 1'b0; done = 1'b1; phase_in = PH_IDLE;
                  end
                  PH_SP1: begin
                     scl_level_in = 1'b1; delay_count_in = delay_load; phase_in = PH_SP2;
                  end
                  PH_SP2: begin
                     sda_level_in = 1'b1; delay_count_in = delay_load; phase_in = PH_SP3;
                  end
                  PH_SP3: begin
                     done = 1'b1; phase_in = PH_IDLE;
                  end
                  PH_WR1: begin
                     sda_level_in   = shift_reg_ff[7];
                     delay_count_in = delay_load;
                     phase_in       = PH_WR2;
                  end
                  PH_WR2: begin
                     scl_level_in = 1'b1; delay_count_in = delay_load; phase_in = PH_WR3;
                  end
                  PH_WR3: begin
                     scl_level_in = 1'b0;
                     shift_reg_in = {shift_reg_ff[6:0], 1'b0};
                     bit_count_in = bit_next;
                     if (bit_next >= 4'd8) begin
                        done     = 1'b1;
                        phase_in = PH_IDLE;
                     end else begin
                        delay_count_in = delay_load;
                        phase_in       = PH_WR1;
                     end
                  end
                  PH_RD1: begin
                     scl_level_in = 1'b1;
                     if (item.sda_in) begin
                        shift_reg_in[3'd7 - bit_count_ff[2:0]] = 1'b1;
                     end
                     delay_count_in = delay_load;
                     phase_in       = PH_RD2;
                  end
                  PH_RD2: begin
                     scl_level_in   = 1'b0;
                     bit_count_in   = bit_next;
                     delay_count_in = delay_load;
                     if (bit_next >= 4'd8) begin
                        sda_level_in = !ack_to_send_ff;
                        phase_in     = PH_RA1;
                     end else begin
                        phase_in = PH_RD1;
                     end
                  end
                  PH_RA1: begin
                     scl_level_in = 1'b1; delay_count_in = delay_load; phase_in = PH_RA2;
                  end
                  PH_RA2: begin
                     scl_level_in     = 1'b0;
                     received_byte_in = shift_reg_ff;
                     done             = 1'b1;
                     phase_in         = PH_IDLE;
                  end
                  default: phase_in = PH_IDLE;
               endcase
            end
         end
      endcase
   end

   assign result.scl         = scl_level_in;
   assign result.sda_release = sda_level_in;
   assign result.busy_res    = (phase_in != PH_IDLE);
   assign result.done_res    = done;
   assign result.rx_data     = received_byte_in;
   assign result.no_ack      = ack_flag_in;

`ifndef SYNTHESIS
   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      result.done_res |-> !result.busy_res)
      else $error("done beat while still busy");

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      !step_fire |=> $stable(phase_ff) && $stable(shift_reg_ff) && $stable(bit_count_ff))
      else $error("sequencer state moved without a beat");

   a_ack_seen: assert property (@(posedge clock) disable iff (reset)
      step_fire && phase_ff == PH_WACK && !item.sda_in
      |=> phase_ff == PH_IDLE && !scl_level_ff && !ack_flag_ff)
      else $error("slave ack not taken");

   a_start_enters: assert property (@(posedge clock) disable iff (reset)
      step_fire && phase_ff == PH_IDLE && item.cmd == CMD_START
      |=> phase_ff == PH_ST1 && delay_count_ff != '0)
      else $error("start command not launched");

   a_bit_count_range: assert property (@(posedge clock) disable iff (reset)
      bit_count_ff <= 4'd8)
      else $error("bit count out of range");
`endif

endmodule
